// ===== design/onps_pkg.sv =====
package onps_pkg;

  localparam int unsigned MAX_NODES     = 4681;
  localparam int unsigned LEAF_CAPACITY = 10;
  localparam int unsigned MAX_POINTS    = 1024;
  localparam int unsigned COORD_BITS    = 16;

  typedef enum logic [2:0] {
    OP_CENTER = 3'd0,
    OP_COUNT  = 3'd1,
    OP_ENTRY  = 3'd2,
    OP_POINT  = 3'd3,
    OP_QUERY  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRD,
    ST_DEV,
    ST_SRD,
    ST_SID,
    ST_SPT,
    ST_SQ,
    ST_SCMP,
    ST_USTART,
    ST_UEV,
    ST_UIT,
    ST_DONE
  } state_e;

  localparam int unsigned STATUS_FOUND = 0;
  localparam int unsigned STATUS_EMPTY = 1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [12:0]        node_index;
    logic [3:0]         leaf_slot;
    logic [3:0]         leaf_count;
    logic [9:0]         point_id;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
  } in_t;

  typedef struct packed {
    logic [9:0]  nearest_id;
    logic [33:0] best_dist_sq;
    logic        status;
  } out_t;

endpackage

// ===== design/octree_nearest_point_search_top.sv =====
// Nearest point search over an implicitly indexed octree (child of node p for region r is
// 8*p+r+1). Write items (node centre, leaf count, leaf entry, point) are accepted while idle
// and produce no result; a query produces exactly one result. After reset the leaf table is
// cleared one node a cycle; no transaction is accepted until it is done. A query descends one
// level per centre read, scans each leaf point by reading its entry and point and squaring
// the three differences, and per level climbed squares the differences to the parent centre
// and steps through up to 8 region indices; every step is paced by a table read and by the
// one shared squaring multiplier. A finished result waits in the output register while
// write items keep being accepted.
module octree_nearest_point_search_top #(
  parameter int unsigned TREE_LEVELS   = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  onps_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output onps_pkg::out_t out_data_o
);
  import onps_pkg::*;

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned NW   = $clog2(MAX_NODES);
  localparam int unsigned XW   = NW + 4;
  localparam int unsigned PW   = $clog2(MAX_POINTS);
  localparam int unsigned EDEP = MAX_NODES * LEAF_CAPACITY;
  localparam int unsigned EW   = $clog2(EDEP);
  localparam int unsigned CW   = $clog2(LEAF_CAPACITY + 1);
  localparam int unsigned DPW  = $clog2(TREE_LEVELS);
  localparam int unsigned SPW  = $clog2(TREE_LEVELS + 1);
  localparam int unsigned TIW  = $clog2(TREE_LEVELS);
  localparam int unsigned DW   = 2 * CB + 2;
  localparam int unsigned PRW  = 2 * CB + 2;

  typedef logic signed [CB-1:0] crd_t;
  typedef logic signed [CB:0]   dif_t;

  // memories
  logic [3*CB-1:0] ctr_mem [MAX_NODES];
  logic [CW:0]     lf_mem  [MAX_NODES];
  logic [PW-1:0]   ent_mem [EDEP];
  logic [3*CB-1:0] pt_mem  [MAX_POINTS];

  logic            ctr_we, lf_we, ent_we, pt_we;
  logic [NW-1:0]   ctr_wa, ctr_ra, lf_wa, lf_ra;
  logic [EW-1:0]   ent_wa, ent_ra;
  logic [PW-1:0]   pt_wa, pt_ra;
  logic [3*CB-1:0] ctr_wd, pt_wd, ctr_rd, pt_rd;
  logic [CW:0]     lf_wd, lf_rd;
  logic [PW-1:0]   ent_wd, ent_rd;

  always_ff @(posedge clk_i) begin
    if (ctr_we) ctr_mem[ctr_wa] <= ctr_wd;
    ctr_rd <= ctr_mem[ctr_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lf_we) lf_mem[lf_wa] <= lf_wd;
    lf_rd <= lf_mem[lf_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_wa] <= pt_wd;
    pt_rd <= pt_mem[pt_ra];
  end

  state_e          state_q, state_d;
  logic [NW-1:0]   clr_q, clr_d;
  logic [XW-1:0]   idx_q, idx_d, par_q, par_d;
  logic [DPW-1:0]  depth_q, depth_d;
  logic [SPW-1:0]  sp_q, sp_d;
  logic            found_q, found_d;
  logic [DW-1:0]   best_q, best_d;
  logic [PW-1:0]   best_id_q, best_id_d, id_q, id_d;
  crd_t            q_q [3];
  crd_t            q_d [3];
  logic [CW-1:0]   k_q, k_d, n_q, n_d;
  dif_t            d_q [3];
  dif_t            d_d [3];
  logic [DW-1:0]   sq_q [3];
  logic [DW-1:0]   sq_d [3];
  logic [1:0]      sqk_q, sqk_d;
  logic            sqret_q, sqret_d;
  logic [2:0]      r_q, r_d, orig_q, orig_d, b_q, b_d;
  logic            resume_q, resume_d;
  logic [3:0]      i_q, i_d;
  logic [XW-1:0]   stn_q [TREE_LEVELS];
  logic [XW-1:0]   stn_d [TREE_LEVELS];
  logic [2:0]      sto_q [TREE_LEVELS];
  logic [2:0]      sto_d [TREE_LEVELS];
  logic [2:0]      stl_q [TREE_LEVELS];
  logic [2:0]      stl_d [TREE_LEVELS];
  logic            ov_q, ov_d;
  out_t            od_q, od_d;

  crd_t            in_c [3];
  crd_t            rd_c [3];
  logic [TIW-1:0]  top;
  logic [XW-1:0]   im1;
  logic [2:0]      reg_bits, x;
  logic            term;
  logic signed [PRW-1:0] dx;
  logic [PRW-1:0]  prod;
  logic [DW-1:0]   sum, di;
  logic [CW-1:0]   sat;

  assign in_c[0] = in_data_i.coord_x[CB-1:0];
  assign in_c[1] = in_data_i.coord_y[CB-1:0];
  assign in_c[2] = in_data_i.coord_z[CB-1:0];
  assign top = TIW'(sp_q - SPW'(1));
  assign im1 = idx_q - XW'(1);

  always_comb begin
    state_d  = state_q;   clr_d    = clr_q;     idx_d   = idx_q;   par_d   = par_q;
    depth_d  = depth_q;   sp_d     = sp_q;      found_d = found_q; best_d  = best_q;
    best_id_d = best_id_q; id_d    = id_q;      q_d     = q_q;     k_d     = k_q;
    n_d      = n_q;       d_d      = d_q;       sq_d    = sq_q;    sqk_d   = sqk_q;
    sqret_d  = sqret_q;   r_d      = r_q;       orig_d  = orig_q;  b_d     = b_q;
    resume_d = resume_q;  i_d      = i_q;       stn_d   = stn_q;   sto_d   = sto_q;
    stl_d    = stl_q;     ov_d     = ov_q;      od_d    = od_q;
    in_ready_o = 1'b0;
    ctr_we = 1'b0; lf_we = 1'b0; ent_we = 1'b0; pt_we = 1'b0;
    ctr_wa = in_data_i.node_index[NW-1:0];
    lf_wa  = in_data_i.node_index[NW-1:0];
    ent_wa = EW'(in_data_i.node_index[NW-1:0]) * EW'(LEAF_CAPACITY)
             + EW'(in_data_i.leaf_slot);
    pt_wa  = in_data_i.point_id[PW-1:0];
    ctr_wd = {in_c[0], in_c[1], in_c[2]};
    pt_wd  = {in_c[0], in_c[1], in_c[2]};
    ent_wd = in_data_i.point_id[PW-1:0];
    sat    = (32'(in_data_i.leaf_count) > LEAF_CAPACITY) ? CW'(LEAF_CAPACITY)
                                                         : CW'(in_data_i.leaf_count);
    lf_wd  = {1'b1, sat};
    ctr_ra = idx_q[NW-1:0];
    lf_ra  = idx_q[NW-1:0];
    ent_ra = EW'(idx_q[NW-1:0]) * EW'(LEAF_CAPACITY) + EW'(k_q);
    pt_ra  = ent_rd;
    rd_c[0] = ctr_rd[3*CB-1:2*CB];
    rd_c[1] = ctr_rd[2*CB-1:CB];
    rd_c[2] = ctr_rd[CB-1:0];
    reg_bits = {q_q[0] >= rd_c[0], q_q[1] >= rd_c[1], q_q[2] >= rd_c[2]};
    term = (32'(idx_q) >= MAX_NODES) || (32'(depth_q) + 1 >= TREE_LEVELS) || lf_rd[CW];
    dx   = PRW'(d_q[sqk_q]);
    prod = dx * dx;
    sum  = sq_q[0] + sq_q[1] + sq_q[2];
    x    = i_q[2:0] ^ b_q;
    di   = (x[2] ? sq_q[0] : '0) + (x[1] ? sq_q[1] : '0) + (x[0] ? sq_q[2] : '0);

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        lf_we = 1'b1;
        lf_wa = clr_q;
        lf_wd = '0;
        clr_d = clr_q + NW'(1);
        if (32'(clr_q) == MAX_NODES - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_data_i.operation)
            OP_CENTER: ctr_we = 32'(in_data_i.node_index) < MAX_NODES;
            OP_COUNT:  lf_we  = 32'(in_data_i.node_index) < MAX_NODES;
            OP_ENTRY:  ent_we = (32'(in_data_i.node_index) < MAX_NODES)
                             && (32'(in_data_i.leaf_slot) < LEAF_CAPACITY)
                             && (32'(in_data_i.point_id) < MAX_POINTS);
            OP_POINT:  pt_we  = 32'(in_data_i.point_id) < MAX_POINTS;
            OP_QUERY: begin
              q_d     = in_c;
              idx_d   = '0;
              depth_d = '0;
              sp_d    = '0;
              found_d = 1'b0;
              best_d  = '0;
              best_id_d = '0;
              state_d = ST_DRD;
            end
            default: ;
          endcase
        end
      end
      ST_DRD: state_d = ST_DEV;
      ST_DEV: begin
        if (!term) begin
          idx_d   = (idx_q << 3) + XW'(reg_bits) + XW'(1);
          depth_d = depth_q + DPW'(1);
          state_d = ST_DRD;
        end else if ((32'(idx_q) < MAX_NODES) && lf_rd[CW]) begin
          n_d = lf_rd[CW-1:0];
          k_d = '0;
          state_d = ST_SRD;
        end else begin
          state_d = ST_USTART;
        end
      end
      ST_SRD: state_d = (k_q >= n_q) ? ST_USTART : ST_SID;
      ST_SID: begin
        id_d = ent_rd;
        state_d = ST_SPT;
      end
      ST_SPT: begin
        d_d[0] = dif_t'(q_q[0]) - dif_t'(crd_t'(pt_rd[3*CB-1:2*CB]));
        d_d[1] = dif_t'(q_q[1]) - dif_t'(crd_t'(pt_rd[2*CB-1:CB]));
        d_d[2] = dif_t'(q_q[2]) - dif_t'(crd_t'(pt_rd[CB-1:0]));
        sqk_d = '0;
        sqret_d = 1'b0;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        sq_d[sqk_q] = DW'(prod);
        if (sqk_q == 2'd2) state_d = sqret_q ? ST_UIT : ST_SCMP;
        else sqk_d = sqk_q + 2'd1;
      end
      ST_SCMP: begin
        if (!found_q || sum < best_q) begin
          found_d = 1'b1;
          best_d = sum;
          best_id_d = id_q;
        end
        k_d = k_q + CW'(1);
        state_d = ST_SRD;
      end
      ST_USTART: begin
        if (idx_q == '0) begin
          state_d = ST_DONE;
        end else begin
          par_d  = im1 >> 3;
          ctr_ra = NW'(im1 >> 3);
          r_d    = im1[2:0];
          if (sp_q != '0 && stn_q[top] == (im1 >> 3)) begin
            resume_d = 1'b1;
            orig_d = sto_q[top];
            i_d = {1'b0, stl_q[top]} + 4'd1;
          end else begin
            resume_d = 1'b0;
            orig_d = im1[2:0];
            i_d = '0;
          end
          state_d = ST_UEV;
        end
      end
      ST_UEV: begin
        for (int j = 0; j < 3; j++) d_d[j] = dif_t'(q_q[j]) - dif_t'(rd_c[j]);
        b_d = {q_q[0] >= rd_c[0], q_q[1] >= rd_c[1], q_q[2] >= rd_c[2]};
        sqk_d = '0;
        sqret_d = 1'b1;
        state_d = ST_SQ;
      end
      ST_UIT: begin
        if (i_q[3]) begin
          idx_d = par_q;
          depth_d = depth_q - DPW'(1);
          if (resume_q) sp_d = sp_q - SPW'(1);
          state_d = ST_USTART;
        end else if (i_q[2:0] == r_q || i_q[2:0] == orig_q) begin
          i_d = i_q + 4'd1;
        end else if (!found_q || di < best_q) begin
          if (resume_q) begin
            stl_d[top] = i_q[2:0];
          end else if (32'(sp_q) < TREE_LEVELS) begin
            stn_d[TIW'(sp_q)] = par_q;
            sto_d[TIW'(sp_q)] = r_q;
            stl_d[TIW'(sp_q)] = i_q[2:0];
            sp_d = sp_q + SPW'(1);
          end
          idx_d = (par_q << 3) + XW'(i_q[2:0]) + XW'(1);
          state_d = ST_DRD;
        end else begin
          i_d = i_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          od_d.nearest_id   = found_q ? 10'(best_id_q) : '0;
          od_d.best_dist_sq = found_q ? 34'(best_q) : '0;
          od_d.status       = found_q ? 1'(STATUS_FOUND) : 1'(STATUS_EMPTY);
          sp_d = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; idx_q <= '0; par_q <= '0; depth_q <= '0;
      sp_q <= '0; found_q <= 1'b0; best_q <= '0; best_id_q <= '0; id_q <= '0;
      k_q <= '0; n_q <= '0; sqk_q <= '0; sqret_q <= 1'b0; r_q <= '0; orig_q <= '0;
      b_q <= '0; resume_q <= 1'b0; i_q <= '0; ov_q <= 1'b0; od_q <= '0;
      for (int j = 0; j < 3; j++) begin
        q_q[j] <= '0; d_q[j] <= '0; sq_q[j] <= '0;
      end
      for (int j = 0; j < TREE_LEVELS; j++) begin
        stn_q[j] <= '0; sto_q[j] <= '0; stl_q[j] <= '0;
      end
    end else begin
      state_q <= state_d; clr_q <= clr_d; idx_q <= idx_d; par_q <= par_d;
      depth_q <= depth_d; sp_q <= sp_d; found_q <= found_d; best_q <= best_d;
      best_id_q <= best_id_d; id_q <= id_d; k_q <= k_d; n_q <= n_d; sqk_q <= sqk_d;
      sqret_q <= sqret_d; r_q <= r_d; orig_q <= orig_d; b_q <= b_d;
      resume_q <= resume_d; i_q <= i_d; ov_q <= ov_d; od_q <= od_d;
      q_q <= q_d; d_q <= d_d; sq_q <= sq_d;
      stn_q <= stn_d; sto_q <= sto_d; stl_q <= stl_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

// ===== design/onps_checker.sv =====
module onps_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input onps_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input onps_pkg::out_t out_data_o
);
  import onps_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |->
      out_data_o.nearest_id == '0 && out_data_o.best_dist_sq == '0)
    else $error("empty result carries data");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.operation == OP_QUERY |=> !in_ready_o)
    else $error("ready after query");

  a_no_result_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.operation != OP_QUERY && !out_valid_o
      |=> !out_valid_o)
    else $error("result without query");

endmodule

bind octree_nearest_point_search_top onps_checker u_onps_checker (.*);

// ===== dv/nearest_point_checker.sv =====
module nearest_point_checker
  import onps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_data_i,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODES  = 4681;
  localparam int unsigned CAP    = 10;
  localparam int unsigned POINTS = 1024;
  localparam int unsigned LEVELS = 5;

  bit signed [15:0] ctr_x [NODES];
  bit signed [15:0] ctr_y [NODES];
  bit signed [15:0] ctr_z [NODES];
  bit               leaf_mark [NODES];
  bit [3:0]         leaf_len [NODES];
  bit [9:0]         slot_id [NODES*CAP];
  bit signed [15:0] pt_x [POINTS];
  bit signed [15:0] pt_y [POINTS];
  bit signed [15:0] pt_z [POINTS];

  out_t nearest_q[$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic bit is_end(int unsigned n, int unsigned dep);
    if (n >= NODES || dep + 1 >= LEVELS) return 1'b1;
    return leaf_mark[n];
  endfunction

  function automatic out_t predict_nearest(logic signed [15:0] qx, logic signed [15:0] qy,
                                           logic signed [15:0] qz);
    longint unsigned best;
    longint unsigned dd, e0, e1, e2;
    longint signed   d0, d1, d2;
    int unsigned     bid, n, dep, par, id;
    int unsigned     stk_node [LEVELS];
    int              stk_orig [LEVELS];
    int              stk_last [LEVELS];
    int              sp, r, o, first, i, x, b, k;
    bit              found, down, resume;
    out_t            res;
    best  = 64'hFFFF_FFFF_FFFF_FFFF;
    bid   = 0;
    found = 1'b0;
    n     = 0;
    dep   = 0;
    sp    = 0;
    forever begin
      down = 1'b0;
      while (!is_end(n, dep)) begin
        x = {(qx >= ctr_x[n]), (qy >= ctr_y[n]), (qz >= ctr_z[n])};
        n = n * 8 + x + 1;
        dep++;
      end
      if (n < NODES && leaf_mark[n]) begin
        for (k = 0; k < int'(leaf_len[n]) && k < CAP; k++) begin
          id = slot_id[n*CAP+k];
          d0 = longint'(qx) - longint'(pt_x[id]);
          d1 = longint'(qy) - longint'(pt_y[id]);
          d2 = longint'(qz) - longint'(pt_z[id]);
          dd = d0 * d0 + d1 * d1 + d2 * d2;
          if (dd < best) begin
            best  = dd;
            bid   = id;
            found = 1'b1;
          end
        end
      end
      while (n != 0) begin
        par    = (n - 1) >> 3;
        r      = (n - 1) & 7;
        o      = r;
        first  = 0;
        resume = 1'b0;
        if (sp > 0 && stk_node[sp-1] == par) begin
          resume = 1'b1;
          o      = stk_orig[sp-1];
          first  = stk_last[sp-1] + 1;
        end
        d0 = longint'(qx) - longint'(ctr_x[par]);
        d1 = longint'(qy) - longint'(ctr_y[par]);
        d2 = longint'(qz) - longint'(ctr_z[par]);
        e0 = d0 * d0;
        e1 = d1 * d1;
        e2 = d2 * d2;
        b  = {(d0 >= 0), (d1 >= 0), (d2 >= 0)};
        for (i = first; i < 8; i++) begin
          if (i == r || i == o) continue;
          x  = i ^ b;
          dd = (x[2] ? e0 : 0) + (x[1] ? e1 : 0) + (x[0] ? e2 : 0);
          if (dd < best) begin
            if (resume) begin
              stk_last[sp-1] = i;
            end else if (sp < LEVELS) begin
              stk_node[sp] = par;
              stk_orig[sp] = r;
              stk_last[sp] = i;
              sp++;
            end
            n    = par * 8 + i + 1;
            down = 1'b1;
            break;
          end
        end
        if (down) break;
        n = par;
        dep--;
        if (resume) sp--;
      end
      if (!down) break;
    end
    if (found) begin
      res.nearest_id   = bid[9:0];
      res.best_dist_sq = best[33:0];
      res.status       = 1'(STATUS_FOUND);
    end else begin
      res.nearest_id   = '0;
      res.best_dist_sq = '0;
      res.status       = 1'(STATUS_EMPTY);
    end
    return res;
  endfunction

  task automatic report(string what, longint unsigned exp_v, longint unsigned got_v);
    $display("%0t mismatch %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    in_t  t;
    out_t e;
    if (rst_ni && in_valid_i && in_ready_i) begin
      t = in_data_i;
      case (op_e'(t.operation))
        OP_CENTER: begin
          if (t.node_index < NODES) begin
            ctr_x[t.node_index] = t.coord_x;
            ctr_y[t.node_index] = t.coord_y;
            ctr_z[t.node_index] = t.coord_z;
          end
        end
        OP_COUNT: begin
          if (t.node_index < NODES) begin
            leaf_len[t.node_index]  = (t.leaf_count > CAP) ? 4'(CAP) : t.leaf_count;
            leaf_mark[t.node_index] = 1'b1;
          end
        end
        OP_ENTRY: begin
          if (t.node_index < NODES && t.leaf_slot < CAP)
            slot_id[t.node_index*CAP+t.leaf_slot] = t.point_id;
        end
        OP_POINT: begin
          pt_x[t.point_id] = t.coord_x;
          pt_y[t.point_id] = t.coord_y;
          pt_z[t.point_id] = t.coord_z;
        end
        OP_QUERY: nearest_q = {nearest_q, predict_nearest(t.coord_x, t.coord_y, t.coord_z)};
        default: ;
      endcase
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (nearest_q.size() == 0) begin
        report("unexpected result, nearest_id", 0, out_data_i.nearest_id);
      end else begin
        e = nearest_q.pop_front();
        if (out_data_i.status !== e.status)
          report("status", e.status, out_data_i.status);
        if (out_data_i.nearest_id !== e.nearest_id)
          report("nearest_id", e.nearest_id, out_data_i.nearest_id);
        if (out_data_i.best_dist_sq !== e.best_dist_sq)
          report("best_dist_sq", e.best_dist_sq, out_data_i.best_dist_sq);
      end
    end
    pending_o <= nearest_q.size();
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  import onps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = $bits(in_t);

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic in_valid   = 1'b0;
  logic out_ready  = 1'b0;
  in_t  in_data    = '0;
  logic in_ready;
  logic out_valid;
  out_t out_data;
  int   errors;
  int   pending;

  bit               inner_node [4681];
  int               leaves[$];
  bit               slot_set [46810];
  bit               pt_set [1024];
  int               pt_pool[$];
  bit signed [15:0] px [1024];
  bit signed [15:0] py [1024];
  bit signed [15:0] pz [1024];
  int               burst_left;

  always #6 clk_i = ~clk_i;

  octree_nearest_point_search_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  nearest_point_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int cyc;
    int n;
    bit held;
    cyc  = 0;
    held = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!held && cyc > 15000) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (600) @(posedge clk_i);
        cyc += 600;
      end
      case ($urandom_range(0, 3))
        0, 1: begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 40);
        end
        2: begin
          out_ready <= 1'b0;
          n = $urandom_range(1, 12);
        end
        default: begin
          out_ready <= ~out_ready;
          n = 1;
        end
      endcase
      repeat (n) @(posedge clk_i);
      cyc += n;
    end
  end

  function automatic in_t fresh(op_e op);
    in_t t;
    t = IW'({$urandom, $urandom, $urandom});
    t.operation = op;
    return t;
  endfunction

  task automatic push(in_t t);
    int gap;
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wr_center(int n, int x, int y, int z);
    in_t t;
    t = fresh(OP_CENTER);
    t.node_index = 13'(n);
    t.coord_x = 16'(x);
    t.coord_y = 16'(y);
    t.coord_z = 16'(z);
    push(t);
  endtask

  task automatic wr_count(int n, int c);
    in_t t;
    t = fresh(OP_COUNT);
    t.node_index = 13'(n);
    t.leaf_count = 4'(c);
    push(t);
  endtask

  task automatic wr_entry(int n, int s, int p);
    in_t t;
    t = fresh(OP_ENTRY);
    t.node_index = 13'(n);
    t.leaf_slot  = 4'(s);
    t.point_id   = 10'(p);
    if (n < 4681 && s < 10) slot_set[n*10+s] = 1'b1;
    push(t);
  endtask

  task automatic wr_point(int p, int x, int y, int z);
    in_t t;
    t = fresh(OP_POINT);
    t.point_id = 10'(p);
    t.coord_x = 16'(x);
    t.coord_y = 16'(y);
    t.coord_z = 16'(z);
    if (!pt_set[p]) pt_pool = {pt_pool, p};
    pt_set[p] = 1'b1;
    px[p] = 16'(x);
    py[p] = 16'(y);
    pz[p] = 16'(z);
    push(t);
  endtask

  task automatic query(int x, int y, int z);
    in_t t;
    t = fresh(OP_QUERY);
    t.coord_x = 16'(x);
    t.coord_y = 16'(y);
    t.coord_z = 16'(z);
    push(t);
  endtask

  task automatic random_query();
    int p;
    if ($urandom_range(0, 2) == 0) begin
      p = pt_pool[$urandom_range(0, pt_pool.size() - 1)];
      query(px[p] + $urandom_range(0, 6) - 3, py[p] + $urandom_range(0, 6) - 3,
            pz[p] + $urandom_range(0, 6) - 3);
    end else begin
      query($urandom, $urandom, $urandom);
    end
  endtask

  task automatic grow(int n, int dep);
    int c;
    inner_node[n] = 1'b1;
    for (int r = 0; r < 8; r++) begin
      c = 8 * n + r + 1;
      if (dep + 1 < 4 && !(n == 0 && r < 2) && $urandom_range(0, 3 + 2 * dep) == 0)
        grow(c, dep + 1);
      else if (dep + 1 == 4 && $urandom_range(0, 1) == 0)
        continue;
      else
        leaves = {leaves, c};
    end
  endtask

  function automatic int free_slot(int n);
    for (int s = 0; s < 10; s++)
      if (!slot_set[n*10+s]) return s;
    return 10;
  endfunction

  task automatic random_count();
    int n;
    int c;
    n = leaves[$urandom_range(0, leaves.size() - 1)];
    c = $urandom_range(0, 15);
    if (((c > 10) ? 10 : c) > free_slot(n)) c = free_slot(n);
    wr_count(n, c);
  endtask

  initial begin
    int k;
    in_t t;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    grow(0, 0);

    for (int n = 0; n < 585; n++)
      if (inner_node[n]) wr_center(n, $urandom, $urandom, $urandom);
    foreach (leaves[i]) wr_count(leaves[i], 0);
    query($urandom, $urandom, $urandom);
    for (int op = 5; op < 8; op++) begin
      t = fresh(OP_QUERY);
      t.operation = 3'(op);
      push(t);
    end

    wr_point(1023, 16'h7fff, 16'h7fff, 16'h7fff);
    wr_entry(leaves[0], 0, 1023);
    wr_count(leaves[0], 1);
    query(16'h8000, 16'h8000, 16'h8000);
    query(16'h7fff, 16'h7fff, 16'h7fff);

    wr_center(8191, $urandom, $urandom, $urandom);
    wr_count(8191, 15);
    wr_entry(8191, 9, 5);
    wr_entry(leaves[0], 15, 5);
    wr_point(0, 16'h8000, 16'h7fff, 16'h8000);
    for (int p = 1; p < 40; p++) wr_point(p, $urandom, $urandom, $urandom);
    for (int s = 0; s < 10; s++)
      wr_entry(leaves[1], s, pt_pool[$urandom_range(0, pt_pool.size() - 1)]);
    wr_count(leaves[1], 15);
    for (int i = 2; i < leaves.size(); i++) begin
      k = $urandom_range(0, 4);
      for (int s = 0; s < k; s++)
        wr_entry(leaves[i], s, pt_pool[$urandom_range(0, pt_pool.size() - 1)]);
      wr_count(leaves[i], k);
    end
    repeat (4) random_query();

    for (int i = 0; i < 720; i++) begin
      if (i == 300) begin
        if (in_valid) begin
          in_valid <= 1'b0;
          @(posedge clk_i);
        end
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      k = $urandom_range(0, 99);
      if (k < 35) begin
        random_query();
      end else if (k < 50) begin
        k = $urandom_range(0, 1023);
        if ($urandom_range(0, 3) == 0)
          wr_point(k, px[pt_pool[0]], py[pt_pool[0]], pz[pt_pool[0]]);
        else
          wr_point(k, $urandom, $urandom, $urandom);
      end else if (k < 66) begin
        wr_entry(leaves[$urandom_range(0, leaves.size() - 1)], $urandom_range(0, 15),
                 pt_pool[$urandom_range(0, pt_pool.size() - 1)]);
      end else if (k < 82) begin
        random_count();
      end else if (k < 90) begin
        wr_center($urandom_range(0, 8191), $urandom, $urandom, $urandom);
      end else if (k < 95) begin
        t = fresh(OP_QUERY);
        t.operation = 3'($urandom_range(5, 7));
        push(t);
      end else begin
        k = $urandom_range(4681, 8191);
        if ($urandom_range(0, 1) == 0) wr_count(k, $urandom_range(0, 15));
        else wr_entry(k, $urandom_range(0, 15), $urandom_range(0, 1023));
      end
    end

    if (in_valid) in_valid <= 1'b0;
    @(posedge clk_i);
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
